@@ rtl/core/indexed_deque_engine_unit_defines.svh @@
// Assertion helpers used by the deque controller RTL.
`ifndef INDEXED_DEQUE_ENGINE_UNIT_DEFINES_SVH
`define INDEXED_DEQUE_ENGINE_UNIT_DEFINES_SVH

// Check a property on every clock edge, masked while reset is asserted.
`define IDQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define IDQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/core/idq_pkg.sv @@
`default_nettype none
package idq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned IDX_W        = 4;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned CNT_W        = 5;

  localparam logic signed [DATA_W-1:0] ERR_DATA = -32'sd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_READ_AT    = 3'd4,
    CMD_REMOVE_AT  = 3'd5,
    CMD_REMOVE_ALL = 3'd6
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADIDX = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    status_e                  status;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/core/idq_slot_unit.sv @@
`default_nettype none
// Map a logical position to a physical slot: (front + logical) mod CAPACITY.
// Both operands stay below 2*CAPACITY, so one compare and subtract suffices.
module idq_slot_unit #(
  parameter int unsigned CAPACITY = idq_pkg::CAPACITY_DEF,
  localparam int unsigned PW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  wire logic [PW-1:0] front_i,
  input  wire logic [CW-1:0] logical_i,
  output logic      [PW-1:0] slot_o
);

  logic [CW:0] sum;
  logic [CW:0] wrapped;

  // Add, then fold back once past the end of the ring
  always_comb begin
    sum     = (CW + 1)'(front_i) + (CW + 1)'(logical_i);
    wrapped = sum - (CW + 1)'(CAPACITY);
    if (sum >= (CW + 1)'(CAPACITY)) begin
      slot_o = PW'(wrapped);
    end else begin
      slot_o = PW'(sum);
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/idq_store.sv @@
`default_nettype none
// Element storage: one write port, one read port with registered read data.
module idq_store #(
  parameter int unsigned DEPTH = idq_pkg::CAPACITY_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [AW-1:0]                    waddr_i,
  input  wire logic signed [idq_pkg::DATA_W-1:0] wdata_i,
  input  wire logic                             re_i,
  input  wire logic [AW-1:0]                    raddr_i,
  output logic signed [idq_pkg::DATA_W-1:0]     rdata_o
);

  logic signed [idq_pkg::DATA_W-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/idq_ctrl.sv @@
`default_nettype none
`include "indexed_deque_engine_unit_defines.svh"
// Command sequencer: decodes one transaction, walks the store through the
// shared slot unit, and holds the result in an output register.
module idq_ctrl #(
  parameter int unsigned CAPACITY = idq_pkg::CAPACITY_DEF,
  localparam int unsigned PW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [idq_pkg::CMD_W-1:0]         command_i,
  input  wire logic signed [idq_pkg::DATA_W-1:0] value_i,
  input  wire logic [idq_pkg::IDX_W-1:0]         index_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output idq_pkg::result_t                       out_res_o,
  output logic [CW-1:0]                          count_o,
  // slot unit
  output logic [PW-1:0]                          slot_front_o,
  output logic [CW-1:0]                          slot_logical_o,
  input  wire logic [PW-1:0]                     slot_i,
  // store
  output logic                                   mem_we_o,
  output logic [PW-1:0]                          mem_waddr_o,
  output logic signed [idq_pkg::DATA_W-1:0]      mem_wdata_o,
  output logic                                   mem_re_o,
  output logic [PW-1:0]                          mem_raddr_o,
  input  wire logic signed [idq_pkg::DATA_W-1:0] mem_rdata_i
);

  localparam int unsigned XW = (CW > idq_pkg::IDX_W) ? CW : idq_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDATA,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SCAN_RD,
    S_SCAN_WR,
    S_HOLD
  } state_e;

  state_e                             state_q, state_d;
  idq_pkg::cmd_e                      cmd_q, cmd_d;
  logic signed [idq_pkg::DATA_W-1:0]  val_q, val_d;
  logic [idq_pkg::IDX_W-1:0]          idx_q, idx_d;
  logic [CW-1:0]                      i_q, i_d;
  logic [CW-1:0]                      j_q, j_d;
  logic [CW-1:0]                      count_q, count_d;
  logic [PW-1:0]                      front_q, front_d;
  logic                               out_valid_q, out_valid_d;
  idq_pkg::result_t                   out_res_q, out_res_d;
  logic [CW-1:0]                      out_count_q, out_count_d;
  idq_pkg::result_t                   pend_q, pend_d;
  logic [CW-1:0]                      pend_count_q, pend_count_d;

  logic             full;
  logic             empty;
  logic             bad_idx;
  logic             out_free;
  logic [CW-1:0]    i_next;
  logic             fin;
  idq_pkg::result_t fin_res;

  assign full     = (count_q == CW'(CAPACITY));
  assign empty    = (count_q == '0);
  assign bad_idx  = (XW'(idx_q) >= XW'(count_q));
  assign out_free = !out_valid_q || !out_stall_i;
  assign i_next   = i_q + CW'(1);

  assign slot_front_o = front_q;
  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_res_o    = out_res_q;
  assign count_o      = out_count_q;

  // Sequence one command
  always_comb begin
    state_d        = state_q;
    cmd_d          = cmd_q;
    val_d          = val_q;
    idx_d          = idx_q;
    i_d            = i_q;
    j_d            = j_q;
    count_d        = count_q;
    front_d        = front_q;
    out_valid_d    = out_valid_q;
    out_res_d      = out_res_q;
    out_count_d    = out_count_q;
    pend_d         = pend_q;
    pend_count_d   = pend_count_q;
    slot_logical_o = '0;
    mem_we_o       = 1'b0;
    mem_waddr_o    = slot_i;
    mem_wdata_o    = val_q;
    mem_re_o       = 1'b0;
    mem_raddr_o    = slot_i;
    fin            = 1'b0;
    fin_res        = '{data: '0, status: idq_pkg::ST_OK};

    // Drop the output once the receiver takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = idq_pkg::cmd_e'(command_i);
          val_d   = value_i;
          idx_d   = index_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (cmd_q)
          idq_pkg::CMD_PUSH_BACK: begin
            slot_logical_o = count_q;
            fin            = 1'b1;
            if (full) begin
              fin_res = '{data: idq_pkg::ERR_DATA, status: idq_pkg::ST_FULL};
            end else begin
              mem_we_o = 1'b1;
              count_d  = count_q + CW'(1);
            end
          end
          idq_pkg::CMD_PUSH_FRONT: begin
            // front - 1 on the ring
            slot_logical_o = CW'(CAPACITY - 1);
            fin            = 1'b1;
            if (full) begin
              fin_res = '{data: idq_pkg::ERR_DATA, status: idq_pkg::ST_FULL};
            end else begin
              mem_we_o = 1'b1;
              front_d  = slot_i;
              count_d  = count_q + CW'(1);
            end
          end
          idq_pkg::CMD_POP_BACK: begin
            slot_logical_o = count_q - CW'(1);
            if (empty) begin
              fin     = 1'b1;
              fin_res = '{data: idq_pkg::ERR_DATA, status: idq_pkg::ST_EMPTY};
            end else begin
              mem_re_o = 1'b1;
              count_d  = count_q - CW'(1);
              state_d  = S_RDATA;
            end
          end
          idq_pkg::CMD_POP_FRONT: begin
            slot_logical_o = CW'(1);
            if (empty) begin
              fin     = 1'b1;
              fin_res = '{data: idq_pkg::ERR_DATA, status: idq_pkg::ST_EMPTY};
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = front_q;
              front_d     = slot_i;
              count_d     = count_q - CW'(1);
              state_d     = S_RDATA;
            end
          end
          idq_pkg::CMD_READ_AT: begin
            slot_logical_o = CW'(idx_q);
            if (bad_idx) begin
              fin     = 1'b1;
              fin_res = '{data: idq_pkg::ERR_DATA, status: idq_pkg::ST_BADIDX};
            end else begin
              mem_re_o = 1'b1;
              state_d  = S_RDATA;
            end
          end
          idq_pkg::CMD_REMOVE_AT: begin
            if (bad_idx) begin
              fin     = 1'b1;
              fin_res = '{data: idq_pkg::ERR_DATA, status: idq_pkg::ST_BADIDX};
            end else begin
              i_d     = CW'(idx_q);
              state_d = S_SHIFT_RD;
            end
          end
          idq_pkg::CMD_REMOVE_ALL: begin
            i_d     = '0;
            j_d     = '0;
            state_d = S_SCAN_RD;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      S_RDATA: begin
        fin     = 1'b1;
        fin_res = '{data: mem_rdata_i, status: idq_pkg::ST_OK};
      end

      // Close the gap: move element i+1 down to i
      S_SHIFT_RD: begin
        slot_logical_o = i_next;
        if (i_next < count_q) begin
          mem_re_o = 1'b1;
          state_d  = S_SHIFT_WR;
        end else begin
          count_d = count_q - CW'(1);
          fin     = 1'b1;
        end
      end

      S_SHIFT_WR: begin
        slot_logical_o = i_q;
        mem_we_o       = 1'b1;
        mem_wdata_o    = mem_rdata_i;
        i_d            = i_next;
        state_d        = S_SHIFT_RD;
      end

      // Compact: keep elements that differ from the value, in order
      S_SCAN_RD: begin
        slot_logical_o = i_q;
        if (i_q < count_q) begin
          mem_re_o = 1'b1;
          state_d  = S_SCAN_WR;
        end else begin
          count_d = j_q;
          fin     = 1'b1;
        end
      end

      S_SCAN_WR: begin
        slot_logical_o = j_q;
        if (mem_rdata_i != val_q) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rdata_i;
          j_d         = j_q + CW'(1);
        end
        i_d     = i_next;
        state_d = S_SCAN_RD;
      end

      S_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = pend_q;
          out_count_d = pend_count_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Hand the result and the count after the command to the output register, or park them
    if (fin) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_res_d   = fin_res;
        out_count_d = count_d;
        state_d     = S_IDLE;
      end else begin
        pend_d       = fin_res;
        pend_count_d = count_d;
        state_d      = S_HOLD;
      end
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= idq_pkg::CMD_PUSH_BACK;
      val_q        <= '0;
      idx_q        <= '0;
      i_q          <= '0;
      j_q          <= '0;
      count_q      <= '0;
      front_q      <= '0;
      out_valid_q  <= 1'b0;
      out_res_q    <= '{data: '0, status: idq_pkg::ST_OK};
      out_count_q  <= '0;
      pend_q       <= '{data: '0, status: idq_pkg::ST_OK};
      pend_count_q <= '0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      val_q        <= val_d;
      idx_q        <= idx_d;
      i_q          <= i_d;
      j_q          <= j_d;
      count_q      <= count_d;
      front_q      <= front_d;
      out_valid_q  <= out_valid_d;
      out_res_q    <= out_res_d;
      out_count_q  <= out_count_d;
      pend_q       <= pend_d;
      pend_count_q <= pend_count_d;
    end
  end

  `IDQ_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "element count exceeds capacity")
  `IDQ_ASSERT(a_front_bound, front_q <= PW'(CAPACITY - 1), "front slot off the ring")
  `IDQ_ASSERT(a_scan_order, (state_q == S_SCAN_RD || state_q == S_SCAN_WR) |-> (j_q <= i_q),
              "compaction write index passed read index")
  `IDQ_ASSERT_ALWAYS(a_idle_no_write, (state_q == S_IDLE) |-> !mem_we_o,
                     "store written while idle")
  `IDQ_ASSERT(a_hold_blocks, (state_q == S_HOLD && out_valid_q && out_stall_i) |=>
              (state_q == S_HOLD && $stable(pend_q)), "parked result lost")

endmodule
`default_nettype wire

@@ rtl/core/indexed_deque_engine_unit.sv @@
`default_nettype none
// Fixed-capacity deque of 32-bit signed values with indexed read and removal.
// Input channel: in_valid_i / in_stall_o carry command_i, value_i, index_i;
// a transaction is taken on a clock edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i carry data_o, status_o, count_o,
// one result per command, in command order.
// Commands run one at a time under a sequencer; in_stall_o is high while a
// command is in progress. Pop and read_at read the store, whose read data is
// registered; remove_at shifts each later element down one position, and
// remove_all scans every element and compacts the kept ones.
// Each element moved or scanned takes a read, then a write back, on the
// single store port pair and the shared slot adder.
// A finished result sits in the output register; the next command is taken
// while it waits. If the receiver stalls and a second result completes, that
// result parks and the input stalls until the output register frees up.
// Reset clears the count, the front position and the output valid; store
// contents are not cleared and only slots holding elements are ever read.
module indexed_deque_engine_unit #(
  parameter int unsigned CAPACITY = idq_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [idq_pkg::CMD_W-1:0]         command_i,
  input  wire logic signed [idq_pkg::DATA_W-1:0] value_i,
  input  wire logic [idq_pkg::IDX_W-1:0]         index_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [idq_pkg::DATA_W-1:0]      data_o,
  output logic [idq_pkg::STAT_W-1:0]             status_o,
  output logic [idq_pkg::CNT_W-1:0]              count_o
);

  localparam int unsigned PW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  idq_pkg::result_t                  res;
  logic [CW-1:0]                     count;
  logic [PW-1:0]                     slot_front;
  logic [CW-1:0]                     slot_logical;
  logic [PW-1:0]                     slot;
  logic                              mem_we;
  logic [PW-1:0]                     mem_waddr;
  logic signed [idq_pkg::DATA_W-1:0] mem_wdata;
  logic                              mem_re;
  logic [PW-1:0]                     mem_raddr;
  logic signed [idq_pkg::DATA_W-1:0] mem_rdata;

  idq_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .value_i        (value_i),
    .index_i        (index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_res_o      (res),
    .count_o        (count),
    .slot_front_o   (slot_front),
    .slot_logical_o (slot_logical),
    .slot_i         (slot),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  idq_slot_unit #(
    .CAPACITY(CAPACITY)
  ) u_slot (
    .front_i   (slot_front),
    .logical_i (slot_logical),
    .slot_o    (slot)
  );

  idq_store #(
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Split the result register into its fields; count keeps the low bits
  assign data_o   = res.data;
  assign status_o = res.status;
  assign count_o  = idq_pkg::CNT_W'(count);

endmodule
`default_nettype wire

@@ tb/indexed_deque_engine_unit_tb.sv @@
`timescale 1ns / 1ps

module indexed_deque_engine_unit_tb;

  localparam int unsigned DEPTH       = idq_pkg::CAPACITY_DEF;
  localparam int unsigned PW          = $clog2(DEPTH);
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned MAX_REPORTS = 10;

  // Command code that the block must ignore
  localparam logic [idq_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

  typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIX} traffic_mode_e;

  typedef struct {
    logic [idq_pkg::DATA_W-1:0] data;
    idq_pkg::status_e           status;
    logic [idq_pkg::CNT_W-1:0]  count;
  } deque_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                              cmd_valid = 1'b0;
  logic [idq_pkg::CMD_W-1:0]         cmd_code  = '0;
  logic signed [idq_pkg::DATA_W-1:0] cmd_value = '0;
  logic [idq_pkg::IDX_W-1:0]         cmd_index = '0;
  logic                              rsp_stall = 1'b0;

  wire                              cmd_stall;
  wire                              rsp_valid;
  wire signed [idq_pkg::DATA_W-1:0] rsp_data;
  wire [idq_pkg::STAT_W-1:0]        rsp_status;
  wire [idq_pkg::CNT_W-1:0]         rsp_count;

  // Shadow copy of the deque contents
  logic [idq_pkg::DATA_W-1:0] model_store [DEPTH];
  logic [PW-1:0]              model_front;
  logic [idq_pkg::CNT_W-1:0]  model_count;

  deque_result_t expected_results[$];
  int unsigned   err_count   = 0;
  int unsigned   cycle_count = 0;
  int unsigned   idle_rate   = 0;
  int unsigned   hold_len    = 0;

  logic [idq_pkg::DATA_W-1:0] value_pool [4] =
    '{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5};

  indexed_deque_engine_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (cmd_valid),
    .in_stall_o  (cmd_stall),
    .command_i   (cmd_code),
    .value_i     (cmd_value),
    .index_i     (cmd_index),
    .out_valid_o (rsp_valid),
    .out_stall_i (rsp_stall),
    .data_o      (rsp_data),
    .status_o    (rsp_status),
    .count_o     (rsp_count)
  );

  always #6 clk = ~clk;

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int unsigned slot_of_pos(int unsigned pos);
    return (int'(model_front) + pos) % DEPTH;
  endfunction

  // Update the shadow deque and queue the result one transaction should give
  task automatic apply_command(input logic [idq_pkg::CMD_W-1:0] code,
                               input logic [idq_pkg::DATA_W-1:0] val,
                               input logic [idq_pkg::IDX_W-1:0] idx);
    deque_result_t              res;
    int unsigned                kept;
    logic [idq_pkg::DATA_W-1:0] elem;
    res.data   = '0;
    res.status = idq_pkg::ST_OK;
    case (code) inside
      idq_pkg::CMD_PUSH_BACK, idq_pkg::CMD_PUSH_FRONT: begin
        if (model_count >= DEPTH) begin
          res.data   = idq_pkg::ERR_DATA;
          res.status = idq_pkg::ST_FULL;
        end else if (code == idq_pkg::CMD_PUSH_BACK) begin
          model_store[slot_of_pos(model_count)] = val;
          model_count++;
        end else begin
          model_front = PW'((model_front + DEPTH - 1) % DEPTH);
          model_store[model_front] = val;
          model_count++;
        end
      end
      idq_pkg::CMD_POP_BACK, idq_pkg::CMD_POP_FRONT: begin
        if (model_count == 0) begin
          res.data   = idq_pkg::ERR_DATA;
          res.status = idq_pkg::ST_EMPTY;
        end else if (code == idq_pkg::CMD_POP_BACK) begin
          res.data = model_store[slot_of_pos(model_count - 1)];
          model_count--;
        end else begin
          res.data    = model_store[model_front];
          model_front = PW'((model_front + 1) % DEPTH);
          model_count--;
        end
      end
      idq_pkg::CMD_READ_AT, idq_pkg::CMD_REMOVE_AT: begin
        if (idx >= model_count) begin
          res.data   = idq_pkg::ERR_DATA;
          res.status = idq_pkg::ST_BADIDX;
        end else if (code == idq_pkg::CMD_READ_AT) begin
          res.data = model_store[slot_of_pos(idx)];
        end else begin
          // close the gap from the back side
          for (int unsigned i = idx; i + 1 < model_count; i++)
            model_store[slot_of_pos(i)] = model_store[slot_of_pos(i + 1)];
          model_count--;
        end
      end
      idq_pkg::CMD_REMOVE_ALL: begin
        kept = 0;
        for (int unsigned i = 0; i < model_count; i++) begin
          elem = model_store[slot_of_pos(i)];
          if (elem != val) begin
            model_store[slot_of_pos(kept)] = elem;
            kept++;
          end
        end
        model_count = idq_pkg::CNT_W'(kept);
      end
      default: ;
    endcase
    res.count = model_count;
    expected_results.insert(expected_results.size(), res);
  endtask

  // Offer one command and hold it until the block takes it
  task automatic issue_command(input logic [idq_pkg::CMD_W-1:0] code,
                               input logic [idq_pkg::DATA_W-1:0] val,
                               input logic [idq_pkg::IDX_W-1:0] idx);
    if (idle_rate != 0 && $urandom_range(1, 100) <= idle_rate) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_code  <= code;
    cmd_value <= val;
    cmd_index <= idx;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    apply_command(code, val, idx);
  endtask

  function automatic logic [idq_pkg::DATA_W-1:0] pick_value();
    if ($urandom_range(0, 1) == 0) return $urandom;
    return value_pool[$urandom_range(0, 3)];
  endfunction

  // Mostly land inside the list, sometimes anywhere
  function automatic logic [idq_pkg::IDX_W-1:0] pick_index();
    if (model_count != 0 && $urandom_range(0, 9) < 8)
      return idq_pkg::IDX_W'($urandom_range(0, model_count - 1));
    return idq_pkg::IDX_W'($urandom_range(0, DEPTH - 1));
  endfunction

  function automatic logic [idq_pkg::CMD_W-1:0] pick_command(traffic_mode_e mode);
    int unsigned r;
    int unsigned push_lim;
    int unsigned pop_lim;
    int unsigned span;
    r        = $urandom_range(0, 99);
    push_lim = (mode == MODE_GROW) ? 55 : (mode == MODE_SHRINK) ? 15 : 35;
    pop_lim  = push_lim + ((mode == MODE_GROW) ? 10 : (mode == MODE_SHRINK) ? 35 : 25);
    span     = (97 - pop_lim) / 3;
    if (r < push_lim)
      return $urandom_range(0, 1) ? idq_pkg::CMD_PUSH_BACK : idq_pkg::CMD_PUSH_FRONT;
    if (r < pop_lim)
      return $urandom_range(0, 1) ? idq_pkg::CMD_POP_BACK : idq_pkg::CMD_POP_FRONT;
    if (r < pop_lim + span) return idq_pkg::CMD_READ_AT;
    if (r < pop_lim + 2 * span) return idq_pkg::CMD_REMOVE_AT;
    if (r < 97) return idq_pkg::CMD_REMOVE_ALL;
    return CMD_UNUSED;
  endfunction

  task automatic run_traffic(input traffic_mode_e mode, input int unsigned num_items);
    for (int unsigned n = 0; n < num_items; n++)
      issue_command(pick_command(mode), pick_value(), pick_index());
  endtask

  // Report a bad result; only the first few get printed
  task automatic note_mismatch(input string what, input deque_result_t want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t: %s: got data %h status %0d count %0d, expected data %h status %0d count %0d",
               $realtime, what, rsp_data, rsp_status, rsp_count,
               want.data, want.status, want.count);
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    deque_result_t want;
    if (rst_n && rsp_valid && !rsp_stall) begin
      if (expected_results.size() == 0) begin
        want = '{data: '0, status: idq_pkg::ST_OK, count: '0};
        note_mismatch("unexpected result", want);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (rsp_data !== want.data || rsp_status !== want.status || rsp_count !== want.count)
          note_mismatch("result mismatch", want);
      end
    end
  end

  // Result side: random stall bursts, or a long hold-off on request
  initial begin : result_stall
    int unsigned burst;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        rsp_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        rsp_stall <= 1'b0;
      end else if (idle_rate != 0 && $urandom_range(1, 100) <= idle_rate) begin
        burst = $urandom_range(1, 10);
        rsp_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // Empty-list errors, extreme values, stored -1, bad indices, unused code
  task automatic test_directed();
    idle_rate = 20;
    issue_command(idq_pkg::CMD_POP_BACK, 32'h0, 4'd0);
    issue_command(idq_pkg::CMD_POP_FRONT, 32'h0, 4'd0);
    issue_command(idq_pkg::CMD_READ_AT, 32'h0, 4'd0);
    issue_command(idq_pkg::CMD_REMOVE_AT, 32'h0, 4'd15);
    issue_command(idq_pkg::CMD_REMOVE_ALL, 32'h0, 4'd0);
    issue_command(CMD_UNUSED, 32'h0, 4'd0);
    issue_command(idq_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFF, 4'd0);
    issue_command(idq_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 4'd15);
    issue_command(idq_pkg::CMD_PUSH_BACK, 32'hFFFF_FFFF, 4'd0);
    issue_command(idq_pkg::CMD_PUSH_FRONT, 32'h0, 4'd0);
    issue_command(idq_pkg::CMD_PUSH_BACK, 32'hFFFF_FFFF, 4'd15);
    issue_command(idq_pkg::CMD_READ_AT, 32'h0, 4'd3);
    issue_command(idq_pkg::CMD_READ_AT, 32'h0, 4'd15);
    issue_command(idq_pkg::CMD_READ_AT, 32'h0, 4'd5);
    issue_command(idq_pkg::CMD_REMOVE_AT, 32'h0, 4'd4);
    issue_command(idq_pkg::CMD_REMOVE_ALL, 32'hFFFF_FFFF, 4'd0);
    issue_command(idq_pkg::CMD_REMOVE_AT, 32'h0, 4'd0);
    issue_command(CMD_UNUSED, 32'hFFFF_FFFF, 4'd15);
    issue_command(idq_pkg::CMD_POP_FRONT, 32'h0, 4'd0);
    issue_command(idq_pkg::CMD_POP_BACK, 32'h0, 4'd0);
    issue_command(idq_pkg::CMD_POP_BACK, 32'h0, 4'd0);
  endtask

  // Fill to capacity, poke the full list, then empty it again
  task automatic test_fill_and_drain();
    idle_rate = 10;
    while (model_count < DEPTH)
      issue_command($urandom_range(0, 1) ? idq_pkg::CMD_PUSH_BACK : idq_pkg::CMD_PUSH_FRONT,
                    pick_value(), idq_pkg::IDX_W'($urandom_range(0, 15)));
    issue_command(idq_pkg::CMD_PUSH_BACK, pick_value(), 4'd0);
    issue_command(idq_pkg::CMD_PUSH_FRONT, pick_value(), 4'd0);
    issue_command(idq_pkg::CMD_READ_AT, 32'h0, 4'd15);
    issue_command(idq_pkg::CMD_REMOVE_AT, 32'h0, 4'd15);
    issue_command(idq_pkg::CMD_PUSH_FRONT, pick_value(), 4'd0);
    issue_command(idq_pkg::CMD_REMOVE_AT, 32'h0, 4'd0);
    issue_command(idq_pkg::CMD_REMOVE_ALL, $urandom, 4'd0);
    while (model_count != 0) begin
      case ($urandom_range(0, 2))
        0: issue_command(idq_pkg::CMD_POP_BACK, $urandom,
                         idq_pkg::IDX_W'($urandom_range(0, 15)));
        1: issue_command(idq_pkg::CMD_POP_FRONT, $urandom,
                         idq_pkg::IDX_W'($urandom_range(0, 15)));
        default: issue_command(idq_pkg::CMD_REMOVE_AT, $urandom,
                               idq_pkg::IDX_W'($urandom_range(0, model_count - 1)));
      endcase
    end
    issue_command(idq_pkg::CMD_POP_FRONT, 32'h0, 4'd0);
  endtask

  // Hold results off long enough that the block stalls its input
  task automatic test_backpressure();
    idle_rate = 0;
    hold_len  = HOLD_CYCLES;
    run_traffic(MODE_MIX, 40);
  endtask

  // Segments of biased random traffic with varying idle rates
  task automatic test_random();
    int unsigned rates [3] = '{0, 10, 30};
    for (int unsigned seg = 0; seg < 28; seg++) begin
      idle_rate = rates[$urandom_range(0, 2)];
      run_traffic(traffic_mode_e'($urandom_range(0, 2)), 50);
    end
  endtask

  // Back-to-back traffic on both sides
  task automatic test_full_rate();
    idle_rate = 0;
    run_traffic(MODE_GROW, 60);
    run_traffic(MODE_MIX, 60);
    run_traffic(MODE_SHRINK, 60);
  endtask

  initial begin
    model_front = '0;
    model_count = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_and_drain();
    test_backpressure();
    test_random();
    test_fill_and_drain();
    test_full_rate();

    // let every outstanding result come back
    cmd_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
